// File: sv/wua_pkg.sv
// ----------------------------------------------------------------------------
// wua_pkg
// Shared widths, command and order codes, and flag types for the wide
// unsigned ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package wua_pkg;

    localparam int WORD_BITS  = 192;
    localparam int LIMB_BITS  = 64;
    localparam int FIELD_BITS = 3 * LIMB_BITS;
    localparam int HALF_BITS  = WORD_BITS / 2;
    localparam int CNT_BITS   = $clog2(WORD_BITS);
    localparam int CMD_BITS   = 3;
    localparam int ORD_BITS   = 2;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [FIELD_BITS-1:0] t_field;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_REM = 3'd4,
        CMD_CMP = 3'd5
    } t_cmd;

    typedef enum logic [ORD_BITS-1:0] {
        ORD_EQ = 2'd0,
        ORD_GT = 2'd1,
        ORD_LT = 2'd2
    } t_order;

    // Status of the shared adder: carry out (no borrow on subtract) and a
    // zero sum.
    typedef struct packed {
        logic carry;
        logic zero;
    } t_add_flags;

endpackage

`default_nettype wire

// File: sv/wua_addsub.sv
// ----------------------------------------------------------------------------
// wua_addsub
// Word-wide adder and subtractor shared by every command, with carry and
// zero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module wua_addsub (
    input  logic [wua_pkg::WORD_BITS-1:0] i_x,
    input  logic [wua_pkg::WORD_BITS-1:0] i_y,
    input  logic                          i_sub,
    output logic [wua_pkg::WORD_BITS-1:0] o_sum,
    output wua_pkg::t_add_flags           o_flags
);
    import wua_pkg::*;

    logic [WORD_BITS:0] total;

    // Subtraction is x plus the inverted y plus one; the carry out is then
    // high exactly when x is not below y.
    assign total = {1'b0, i_x} + {1'b0, i_y ^ {WORD_BITS{i_sub}}}
                 + (WORD_BITS+1)'(i_sub);

    assign o_sum         = total[WORD_BITS-1:0];
    assign o_flags.carry = total[WORD_BITS];
    assign o_flags.zero  = ~|total[WORD_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/wide_unsigned_alu.sv
// ----------------------------------------------------------------------------
// wide_unsigned_alu
// Multiprecision unsigned ALU: add, subtract, multiply, divide, remainder and
// compare on 192-bit operands, one bit of multiplier or dividend per cycle.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | into      | i_in_valid / o_in_stall   | i_command, i_operand_a_*, i_operand_b_*
//   out     | out of    | o_out_valid / i_out_stall | o_result_*, o_order, o_divide_by_zero
//
// Add, subtract, compare and a zero divisor go straight to the finishing state.
// Multiply steps through the low WORD_BITS/2 multiplier bits, one multiplier bit a cycle.
// Divide and remainder step through every dividend bit, one quotient bit a cycle.
// The single word-wide adder is used once per cycle.
// A new word is taken while the previous result still waits in the output
// register; reset (synchronous, active low) empties the block.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_unsigned_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wua_pkg::CMD_BITS-1:0]  i_command,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_a_lo,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_a_mid,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_a_hi,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_b_lo,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_b_mid,
    input  logic [wua_pkg::LIMB_BITS-1:0] i_operand_b_hi,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wua_pkg::LIMB_BITS-1:0] o_result_lo,
    output logic [wua_pkg::LIMB_BITS-1:0] o_result_mid,
    output logic [wua_pkg::LIMB_BITS-1:0] o_result_hi,
    output logic [wua_pkg::ORD_BITS-1:0]  o_order,
    output logic                          o_divide_by_zero
);
    import wua_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_word  r_res, n_res;
    t_order r_order, n_order;
    logic   r_dz, n_dz;

    // Serial datapath: r_x is the multiplicand (shifting left) or the
    // dividend that turns into the quotient; r_y is the multiplier
    // (shifting right) or the divisor.
    t_word               r_acc, n_acc;
    t_word               r_x, n_x;
    t_word               r_y, n_y;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_cmd                r_cmd, n_cmd;
    logic                r_bzero, n_bzero;

    t_word      a_word, b_word;
    t_word      add_x, add_y, sum;
    logic       add_sub;
    t_add_flags flags;
    t_word      rem_sh;
    logic       take;
    t_word      fin_res;
    t_order     fin_order;
    logic       fin_dz;
    t_field     res_field;

    assign a_word = WORD_BITS'({i_operand_a_hi, i_operand_a_mid, i_operand_a_lo});
    assign b_word = WORD_BITS'({i_operand_b_hi, i_operand_b_mid, i_operand_b_lo});

    // Partial remainder shifted left with the next dividend bit brought in.
    assign rem_sh = {r_acc[WORD_BITS-2:0], r_x[WORD_BITS-1]};
    // The bit shifted out of the remainder counts as 2^WORD_BITS.
    assign take   = r_acc[WORD_BITS-1] | flags.carry;

    always_comb begin
        unique case (r_state)
            ST_MUL: begin
                add_x   = r_acc;
                add_y   = r_x;
                add_sub = 1'b0;
            end
            ST_DIV: begin
                add_x   = rem_sh;
                add_y   = r_y;
                add_sub = 1'b1;
            end
            ST_IDLE, ST_FIN: begin
                add_x   = r_x;
                add_y   = r_y;
                add_sub = (r_cmd != CMD_ADD);
            end
        endcase
    end

    wua_addsub u_addsub (
        .i_x     (add_x),
        .i_y     (add_y),
        .i_sub   (add_sub),
        .o_sum   (sum),
        .o_flags (flags)
    );

    always_comb begin
        fin_res   = '0;
        fin_order = ORD_EQ;
        fin_dz    = 1'b0;
        unique case (r_cmd)
            CMD_ADD, CMD_SUB: begin
                fin_res = sum;
            end
            CMD_MUL: begin
                fin_res = r_acc;
            end
            CMD_DIV: begin
                fin_dz  = r_bzero;
                fin_res = r_bzero ? '0 : r_x;
            end
            CMD_REM: begin
                fin_dz  = r_bzero;
                fin_res = r_bzero ? r_x : r_acc;
            end
            CMD_CMP: begin
                if (flags.zero) begin
                    fin_order = ORD_EQ;
                end else if (flags.carry) begin
                    fin_order = ORD_GT;
                end else begin
                    fin_order = ORD_LT;
                end
            end
            default: begin
                fin_res = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        n_res       = r_res;
        n_order     = r_order;
        n_dz        = r_dz;
        n_acc       = r_acc;
        n_x         = r_x;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_bzero     = r_bzero;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_acc   = '0;
                    n_x     = a_word;
                    n_y     = b_word;
                    n_cmd   = t_cmd'(i_command);
                    n_bzero = ~|b_word;
                    priority if (t_cmd'(i_command) == CMD_MUL) begin
                        n_cnt   = CNT_BITS'(HALF_BITS - 1);
                        n_state = ST_MUL;
                    end else if ((t_cmd'(i_command) == CMD_DIV
                                  || t_cmd'(i_command) == CMD_REM) && |b_word) begin
                        n_cnt   = CNT_BITS'(WORD_BITS - 1);
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                if (r_y[0]) begin
                    n_acc = sum;
                end
                n_x   = {r_x[WORD_BITS-2:0], 1'b0};
                n_y   = {1'b0, r_y[WORD_BITS-1:1]};
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                n_acc = take ? sum : rem_sh;
                n_x   = {r_x[WORD_BITS-2:0], take};
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_res       = fin_res;
                    n_order     = fin_order;
                    n_dz        = fin_dz;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_res       <= n_res;
            r_order     <= n_order;
            r_dz        <= n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_x     <= n_x;
        r_y     <= n_y;
        r_cnt   <= n_cnt;
        r_cmd   <= n_cmd;
        r_bzero <= n_bzero;
    end

    assign res_field        = FIELD_BITS'(r_res);
    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_lo      = res_field[LIMB_BITS-1:0];
    assign o_result_mid     = res_field[2*LIMB_BITS-1:LIMB_BITS];
    assign o_result_hi      = res_field[3*LIMB_BITS-1:2*LIMB_BITS];
    assign o_order          = r_order;
    assign o_divide_by_zero = r_dz;

`ifndef SYNTHESIS
    // Once a word is taken, the input side closes until its result is stored.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input side stayed open after a word was taken");

    // A compare outcome always comes with a zero arithmetic result.
    a_order_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order != ORD_EQ)
        |-> (o_result_lo == '0 && o_result_mid == '0 && o_result_hi == '0))
        else $error("compare outcome with nonzero result");

    // A zero divisor flag never comes together with a compare outcome.
    a_dz_no_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (o_order == ORD_EQ))
        else $error("divide by zero flag on a compare");

    // Division keeps iterating until the bit counter runs out.
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != '0) |=> (r_state == ST_DIV))
        else $error("division left early");

    // A finished word with a free output slot shows up at the output.
    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && (!o_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
